[design/apwa_pkg.sv]
package apwa_pkg;

  // Field widths
  localparam int TIME_W      = 32;
  localparam int GAP_W       = 8;
  localparam int CNT_W       = 9;
  localparam int SPD_W       = 8;
  localparam int SUM_SHORT_W = 13;
  localparam int SUM_MID_W   = 15;
  localparam int SUM_LONG_W  = 21;
  localparam int SPEED_OUT_W = 17;

  // Stream words
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 112;

  // Default ring depths
  localparam int SHORT_DEPTH_DEF = 10;
  localparam int MID_DEPTH_DEF   = 6;
  localparam int LONG_DEPTH_DEF  = 60;

  // Register port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP     = 2'd0,
    CFG_COUNT_LIMIT = 2'd1,
    CFG_SPEED       = 2'd2
  } cfg_idx_t;

  // Register reset values
  localparam logic [GAP_W-1:0] MIN_GAP_RST     = 8'd3;
  localparam logic [CNT_W-1:0] COUNT_LIMIT_RST = 9'd500;
  localparam logic [SPD_W-1:0] SPEED_RST       = 8'd33;

endpackage

[design/apwa_ring.sv]
// Rolling-sum ring held in a synchronous memory. The entry at the write
// position is prefetched every cycle, so a push needs no separate read access.
module apwa_ring #(
  parameter int DEPTH = apwa_pkg::SHORT_DEPTH_DEF,
  parameter int VAL_W = apwa_pkg::CNT_W,
  parameter int SUM_W = apwa_pkg::SUM_SHORT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req,
  input  logic             fire,
  input  logic [VAL_W-1:0] value,
  output logic [SUM_W-1:0] total_next,
  output logic             wrap
);

  localparam int POS_W = $clog2(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;
  logic [VAL_W-1:0] old_val;
  logic [DEPTH-1:0] filled;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [SUM_W-1:0] total;
  logic             last_slot;
  logic             write_en;

  assign last_slot = (pos == POS_W'(DEPTH - 1));
  assign write_en  = fire && req;
  // Entries never written since reset read as zero.
  assign old_val   = filled[pos] ? rd_data : '0;
  assign wrap      = req && last_slot;
  assign total_next = req ? (total - SUM_W'(old_val) + SUM_W'(value)) : total;

  always_comb begin
    pos_next = pos;
    if (write_en) begin
      pos_next = last_slot ? '0 : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= '0;
      total  <= '0;
    end else if (write_en) begin
      pos         <= pos_next;
      filled[pos] <= 1'b1;
      total       <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[pos] <= value;
    end
    rd_data <= mem[pos_next];
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(DEPTH - 1))
    else $error("ring position out of range");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (filled == '0) |-> (total == '0))
    else $error("ring sum not zero while no entry written");

  a_sum_holds_new: assert property (@(posedge clk) disable iff (rst)
    write_en |=> (total >= SUM_W'($past(value))))
    else $error("ring sum smaller than the entry just written");
`endif

endmodule

[design/apwa_cdiv.sv]
// Floor division by a constant through a reciprocal multiply; exact for
// every numerator of N_W bits.
module apwa_cdiv #(
  parameter int N_W     = 29,
  parameter int DIVISOR = 3600,
  parameter int Q_W     = apwa_pkg::SPEED_OUT_W
) (
  input  logic [N_W-1:0] x,
  output logic [Q_W-1:0] q
);

  localparam int SHIFT  = N_W + $clog2(DIVISOR);
  localparam int PROD_W = (2 * N_W + 1 > SHIFT + Q_W) ? (2 * N_W + 1) : (SHIFT + Q_W);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [N_W:0] RECIP = RECIP_FULL[N_W:0];

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(x) * PROD_W'(RECIP);
  assign q    = prod[SHIFT +: Q_W];

endmodule

[design/anemometer_pulse_window_averager.sv]
// Each word runs through the registered debounce, ring, scale and divide stages.
// Throughput: one word per cycle while the receiver holds m_tready high; each
// ring level reads, modifies and writes back its memory in a single pipeline
// stage, the entry being prefetched.
// Reset (synchronous, rst high) restores the register defaults, clears the
// debounce time, the per-second count, ring positions, sums and entry valid
// bits at once; no clearing pass is needed and words are taken straight away.
module anemometer_pulse_window_averager #(
  parameter int SHORT_DEPTH = apwa_pkg::SHORT_DEPTH_DEF,
  parameter int MID_DEPTH   = apwa_pkg::MID_DEPTH_DEF,
  parameter int LONG_DEPTH  = apwa_pkg::LONG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [apwa_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms
  input  logic                            s_tuser,   // mode: 0 pulse, 1 tick
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [8:0] second_count, [21:9] sum_short, [36:22] sum_mid, [57:37] sum_long,
  // [74:58] speed_10s_cms, [91:75] speed_60s_cms, [108:92] speed_3600s_cms,
  // [111:109] zero
  output logic [apwa_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tuser,   // pulse_accepted
  // Register writes
  input  logic                            cfg_we,
  input  logic [apwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apwa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = apwa_pkg::CNT_W;
  localparam int SPD_W = apwa_pkg::SPD_W;
  localparam int Q_W   = apwa_pkg::SPEED_OUT_W;

  // Sum widths follow from the largest count and the ring depths.
  localparam int CNT_MAX   = 2 ** CNT_W - 1;
  localparam int SHORT_W   = $clog2(CNT_MAX * SHORT_DEPTH + 1);
  localparam int MID_W     = $clog2(CNT_MAX * SHORT_DEPTH * MID_DEPTH + 1);
  localparam int LONG_W    = $clog2(CNT_MAX * SHORT_DEPTH * MID_DEPTH * LONG_DEPTH + 1);
  localparam int PS_W      = SHORT_W + SPD_W;
  localparam int PM_W      = MID_W + SPD_W;
  localparam int PL_W      = LONG_W + SPD_W;
  localparam int DIV_SHORT = SHORT_DEPTH;
  localparam int DIV_MID   = SHORT_DEPTH * MID_DEPTH;
  localparam int DIV_LONG  = SHORT_DEPTH * MID_DEPTH * LONG_DEPTH;

  // Configuration registers
  logic [apwa_pkg::GAP_W-1:0] min_gap;
  logic [CNT_W-1:0]           count_limit;
  logic [SPD_W-1:0]           speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap     <= apwa_pkg::MIN_GAP_RST;
      count_limit <= apwa_pkg::COUNT_LIMIT_RST;
      speed       <= apwa_pkg::SPEED_RST;
    end else if (cfg_we) begin
      case (apwa_pkg::cfg_idx_t'(cfg_index))
        apwa_pkg::CFG_MIN_GAP:     min_gap     <= cfg_data[apwa_pkg::GAP_W-1:0];
        apwa_pkg::CFG_COUNT_LIMIT: count_limit <= cfg_data[CNT_W-1:0];
        apwa_pkg::CFG_SPEED:       speed       <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. A stage takes a word when it is empty or its own
  // word moves on in the same cycle, so the output register alone decides
  // whether a waiting result blocks anything.
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;
  logic in_fire;

  assign r6       = !v6 || m_tready;
  assign r5       = !v5 || r6;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign s_tready = r1;
  assign in_fire  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // Stage one: debounce and per-second count. The gap is the wrapping
  // difference between the word's time stamp and the last accepted pulse.
  logic [apwa_pkg::TIME_W-1:0] last_time;
  logic [CNT_W-1:0]            pulse_count;
  logic [apwa_pkg::TIME_W-1:0] gap;
  logic                        is_tick;
  logic                        gap_ok;
  logic [CNT_W-1:0]            count_next;

  assign is_tick = s_tuser;
  assign gap     = s_tdata[apwa_pkg::TIME_W-1:0] - last_time;
  assign gap_ok  = !is_tick && (gap > apwa_pkg::TIME_W'(min_gap));

  always_comb begin
    count_next = pulse_count;
    if (is_tick) begin
      count_next = '0;
    end else if (gap_ok && (pulse_count < count_limit)) begin
      count_next = pulse_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      pulse_count <= '0;
    end else if (in_fire) begin
      pulse_count <= count_next;
      if (gap_ok) begin
        last_time <= s_tdata[apwa_pkg::TIME_W-1:0];
      end
    end
  end

  logic             acc1, push1;
  logic [CNT_W-1:0] cnt1, val1;

  always_ff @(posedge clk) begin
    if (r1) begin
      acc1  <= gap_ok;
      cnt1  <= count_next;
      push1 <= is_tick;
      val1  <= pulse_count;
    end
  end

  // Stage two: ten-second ring. A tick stores the finished second's count.
  logic [SHORT_W-1:0] short_total_next;
  logic               short_wrap;

  apwa_ring #(
    .DEPTH (SHORT_DEPTH),
    .VAL_W (CNT_W),
    .SUM_W (SHORT_W)
  ) u_short_ring (
    .clk        (clk),
    .rst        (rst),
    .req        (push1),
    .fire       (v1 && r2),
    .value      (val1),
    .total_next (short_total_next),
    .wrap       (short_wrap)
  );

  logic               acc2, push2;
  logic [CNT_W-1:0]   cnt2;
  logic [SHORT_W-1:0] short2;

  always_ff @(posedge clk) begin
    if (r2) begin
      acc2   <= acc1;
      cnt2   <= cnt1;
      short2 <= short_total_next;
      push2  <= short_wrap;
    end
  end

  // Stage three: minute ring. When the short ring wraps its fresh sum is
  // carried down as the value to store.
  logic [MID_W-1:0] mid_total_next;
  logic             mid_wrap;

  apwa_ring #(
    .DEPTH (MID_DEPTH),
    .VAL_W (SHORT_W),
    .SUM_W (MID_W)
  ) u_mid_ring (
    .clk        (clk),
    .rst        (rst),
    .req        (push2),
    .fire       (v2 && r3),
    .value      (short2),
    .total_next (mid_total_next),
    .wrap       (mid_wrap)
  );

  logic               acc3, push3;
  logic [CNT_W-1:0]   cnt3;
  logic [SHORT_W-1:0] short3;
  logic [MID_W-1:0]   mid3;

  always_ff @(posedge clk) begin
    if (r3) begin
      acc3   <= acc2;
      cnt3   <= cnt2;
      short3 <= short2;
      mid3   <= mid_total_next;
      push3  <= mid_wrap;
    end
  end

  // Stage four: hour ring.
  logic [LONG_W-1:0] long_total_next;
  logic              long_wrap;

  apwa_ring #(
    .DEPTH (LONG_DEPTH),
    .VAL_W (MID_W),
    .SUM_W (LONG_W)
  ) u_long_ring (
    .clk        (clk),
    .rst        (rst),
    .req        (push3),
    .fire       (v3 && r4),
    .value      (mid3),
    .total_next (long_total_next),
    .wrap       (long_wrap)
  );

  logic               acc4;
  logic [CNT_W-1:0]   cnt4;
  logic [SHORT_W-1:0] short4;
  logic [MID_W-1:0]   mid4;
  logic [LONG_W-1:0]  long4;

  // The hour ring's wrap carries nothing further.
  always_ff @(posedge clk) begin
    if (r4) begin
      acc4   <= acc3;
      cnt4   <= cnt3;
      short4 <= short3;
      mid4   <= mid3;
      long4  <= long_wrap ? long_total_next : long_total_next;
    end
  end

  // Stage five: scale each sum by the speed of one pulse per second.
  logic               acc5;
  logic [CNT_W-1:0]   cnt5;
  logic [SHORT_W-1:0] short5;
  logic [MID_W-1:0]   mid5;
  logic [LONG_W-1:0]  long5;
  logic [PS_W-1:0]    prod_s;
  logic [PM_W-1:0]    prod_m;
  logic [PL_W-1:0]    prod_l;

  always_ff @(posedge clk) begin
    if (r5) begin
      acc5   <= acc4;
      cnt5   <= cnt4;
      short5 <= short4;
      mid5   <= mid4;
      long5  <= long4;
      prod_s <= PS_W'(short4) * PS_W'(speed);
      prod_m <= PM_W'(mid4) * PM_W'(speed);
      prod_l <= PL_W'(long4) * PL_W'(speed);
    end
  end

  // Stage six: divide by the window length in seconds, floored, and hold
  // the result word until it is taken.
  logic [Q_W-1:0] q_s, q_m, q_l;

  apwa_cdiv #(.N_W (PS_W), .DIVISOR (DIV_SHORT), .Q_W (Q_W)) u_div_short (
    .x (prod_s),
    .q (q_s)
  );

  apwa_cdiv #(.N_W (PM_W), .DIVISOR (DIV_MID), .Q_W (Q_W)) u_div_mid (
    .x (prod_m),
    .q (q_m)
  );

  apwa_cdiv #(.N_W (PL_W), .DIVISOR (DIV_LONG), .Q_W (Q_W)) u_div_long (
    .x (prod_l),
    .q (q_l)
  );

  logic               acc6;
  logic [CNT_W-1:0]   cnt6;
  logic [SHORT_W-1:0] short6;
  logic [MID_W-1:0]   mid6;
  logic [LONG_W-1:0]  long6;
  logic [Q_W-1:0]     spd_s6, spd_m6, spd_l6;

  always_ff @(posedge clk) begin
    if (r6) begin
      acc6   <= acc5;
      cnt6   <= cnt5;
      short6 <= short5;
      mid6   <= mid5;
      long6  <= long5;
      spd_s6 <= q_s;
      spd_m6 <= q_m;
      spd_l6 <= q_l;
    end
  end

  assign m_tvalid = v6;
  assign m_tuser  = acc6;
  assign m_tdata  = {
    3'b000,
    spd_l6,
    spd_m6,
    spd_s6,
    apwa_pkg::SUM_LONG_W'(long6),
    apwa_pkg::SUM_MID_W'(mid6),
    apwa_pkg::SUM_SHORT_W'(short6),
    cnt6
  };

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import apwa_pkg::*;

  // Item kinds carried on s_tuser.
  localparam logic MODE_PULSE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Fixed averaging divisors at the default ring depths.
  localparam longint unsigned DIV_10S   = SHORT_DEPTH_DEF;
  localparam longint unsigned DIV_60S   = SHORT_DEPTH_DEF * MID_DEPTH_DEF;
  localparam longint unsigned DIV_3600S = SHORT_DEPTH_DEF * MID_DEPTH_DEF * LONG_DEPTH_DEF;

  // Cycles to let pass after the last result word before the verdict.
  localparam int unsigned DRAIN_CYCLES = 12;

  // Receiver back-pressure styles.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_LONG_STALL
  } stall_style_t;

  // One expected result word, split into its fields.
  typedef struct {
    logic                   accepted;
    logic [CNT_W-1:0]       count;
    logic [SUM_SHORT_W-1:0] sum_short;
    logic [SUM_MID_W-1:0]   sum_mid;
    logic [SUM_LONG_W-1:0]  sum_long;
    logic [SPEED_OUT_W-1:0] speed_10s;
    logic [SPEED_OUT_W-1:0] speed_60s;
    logic [SPEED_OUT_W-1:0] speed_3600s;
  } wind_word_t;

  // Tracks the debounce, the per-second count and the three cascaded rings,
  // and holds the result words that the block still owes.
  class wind_average_tracker;
    logic [GAP_W-1:0]  gap_ms;
    logic [CNT_W-1:0]  ceiling;
    logic [SPD_W-1:0]  cms_per_pulse;
    logic [TIME_W-1:0] last_stamp;
    int unsigned       pulse_count;
    int unsigned       short_ring[SHORT_DEPTH_DEF];
    int unsigned       mid_ring[MID_DEPTH_DEF];
    int unsigned       long_ring[LONG_DEPTH_DEF];
    int unsigned       short_at, mid_at, long_at;
    int unsigned       short_sum, mid_sum, long_sum;
    wind_word_t        owed_words[$];
    int unsigned       mismatch_count;

    function new();
      gap_ms         = MIN_GAP_RST;
      ceiling        = COUNT_LIMIT_RST;
      cms_per_pulse  = SPEED_RST;
      last_stamp     = '0;
      pulse_count    = 0;
      short_ring     = '{default: 0};
      mid_ring       = '{default: 0};
      long_ring      = '{default: 0};
      short_at       = 0;
      mid_at         = 0;
      long_at        = 0;
      short_sum      = 0;
      mid_sum        = 0;
      long_sum       = 0;
      mismatch_count = 0;
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Register writes keep only the bits that each register holds.
    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_MIN_GAP:     gap_ms        = value[GAP_W-1:0];
        CFG_COUNT_LIMIT: ceiling       = value[CNT_W-1:0];
        CFG_SPEED:       cms_per_pulse = value[SPD_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_long(int unsigned v);
      long_sum = long_sum - long_ring[long_at] + v;
      long_ring[long_at] = v;
      long_at = (long_at + 1 >= LONG_DEPTH_DEF) ? 0 : long_at + 1;
    endfunction

    // A wrap of the ten-second ring pushes its sum down one level.
    function void push_mid(int unsigned v);
      mid_sum = mid_sum - mid_ring[mid_at] + v;
      mid_ring[mid_at] = v;
      if (mid_at + 1 >= MID_DEPTH_DEF) begin
        mid_at = 0;
        push_long(mid_sum);
      end else begin
        mid_at = mid_at + 1;
      end
    endfunction

    function void push_short(int unsigned v);
      short_sum = short_sum - short_ring[short_at] + v;
      short_ring[short_at] = v;
      if (short_at + 1 >= SHORT_DEPTH_DEF) begin
        short_at = 0;
        push_mid(short_sum);
      end else begin
        short_at = short_at + 1;
      end
    endfunction

    // Called for every word the block accepts; works out the word it owes.
    function void take_event(logic is_tick, logic [TIME_W-1:0] stamp);
      wind_word_t        w;
      logic [TIME_W-1:0] since;
      int unsigned       closed;
      w.accepted = 1'b0;
      if (is_tick == MODE_PULSE) begin
        // The difference wraps at 32 bits, so a stamp just past zero still
        // counts as later than one near the top of the range.
        since = stamp - last_stamp;
        if (since > TIME_W'(gap_ms)) begin
          w.accepted = 1'b1;
          last_stamp = stamp;
          // At or above the ceiling the count simply holds.
          if (pulse_count < ceiling) pulse_count++;
        end
      end else begin
        closed      = pulse_count;
        pulse_count = 0;
        push_short(closed);
      end
      w.count       = CNT_W'(pulse_count);
      w.sum_short   = SUM_SHORT_W'(short_sum);
      w.sum_mid     = SUM_MID_W'(mid_sum);
      w.sum_long    = SUM_LONG_W'(long_sum);
      w.speed_10s   = SPEED_OUT_W'(longint'(short_sum) * cms_per_pulse / DIV_10S);
      w.speed_60s   = SPEED_OUT_W'(longint'(mid_sum) * cms_per_pulse / DIV_60S);
      w.speed_3600s = SPEED_OUT_W'(longint'(long_sum) * cms_per_pulse / DIV_3600S);
      owed_words.push_back(w);
    endfunction

    task report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      mismatch_count++;
    endtask

    task compare_field(string name, longint unsigned got, longint unsigned want);
      if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_word(logic accepted, logic [OUT_DATA_W-1:0] word);
      wind_word_t w;
      if (owed_words.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        w = owed_words.pop_front();
        compare_field("pulse_accepted", accepted, w.accepted);
        compare_field("second_count", word[8:0], w.count);
        compare_field("sum_short", word[21:9], w.sum_short);
        compare_field("sum_mid", word[36:22], w.sum_mid);
        compare_field("sum_long", word[57:37], w.sum_long);
        compare_field("speed_10s_cms", word[74:58], w.speed_10s);
        compare_field("speed_60s_cms", word[91:75], w.speed_60s);
        compare_field("speed_3600s_cms", word[108:92], w.speed_3600s);
        compare_field("padding", word[111:109], 0);
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [31:0] now_ms
  logic                  s_tuser   = 1'b0; // mode
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // second_count up to speed_3600s_cms
  logic                  m_tuser;          // pulse_accepted
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  wind_average_tracker tracker = new();

  // Sender pacing: words go out in bursts, mostly separated by idle gaps.
  int unsigned       burst_left = 0;
  // Millisecond clock of the stimulus and the debounce gap now in force.
  logic [TIME_W-1:0] stamp_cursor;
  int unsigned       live_gap = MIN_GAP_RST;

  // Receiver pacing state.
  stall_style_t ready_style = READY_ALWAYS;
  int unsigned  style_left  = 0;
  int unsigned  ready_tick  = 0;

  anemometer_pulse_window_averager dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A generous wall that no correct run comes near, however hard the
  // receiver stalls.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver switches between always ready, coin-toss, sparse and long
  // stalls, so that back-pressure hits every stage of the pipeline.
  always @(negedge clk) begin
    if (style_left == 0) begin
      ready_style = stall_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(50, 400);
    end
    style_left--;
    ready_tick++;
    case (ready_style)
      READY_ALWAYS:     m_tready <= 1'b1;
      READY_COIN:       m_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE:     m_tready <= (ready_tick % 5) == 0;
      READY_LONG_STALL: m_tready <= (ready_tick % 32) >= 24;
      default:          m_tready <= 1'b1;
    endcase
  end

  // Every result word is checked at the edge on which it is taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
  end

  // Offers one word from a falling edge and returns at the falling edge after
  // it has been taken. Between bursts the valid line drops for a gap; a gap
  // of zero keeps it high, so it is never lowered and raised in one step.
  task automatic send_word(input logic mode, input logic [TIME_W-1:0] stamp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= stamp;
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    tracker.take_event(mode, stamp);
    burst_left--;
    @(negedge clk);
  endtask

  // Registers are only written once every owed word has come back. The
  // eight-bit registers get a random ninth bit, which they must drop.
  task automatic apply_settings(input int unsigned gap, input int unsigned limit,
                                input int unsigned speed);
    logic [CFG_DATA_W-1:0] value;
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    value = {1'($urandom_range(0, 1)), 8'(gap)};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_GAP;
    cfg_data  <= value;
    tracker.set_register(CFG_MIN_GAP, value);
    @(negedge clk);
    value = 9'(limit);
    cfg_index <= CFG_COUNT_LIMIT;
    cfg_data  <= value;
    tracker.set_register(CFG_COUNT_LIMIT, value);
    @(negedge clk);
    value = {1'($urandom_range(0, 1)), 8'(speed)};
    cfg_index <= CFG_SPEED;
    cfg_data  <= value;
    tracker.set_register(CFG_SPEED, value);
    @(negedge clk);
    value = 9'($urandom);
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= value;
    tracker.set_register(CFG_UNMAPPED, value);
    @(negedge clk);
    cfg_we   <= 1'b0;
    live_gap = 8'(gap);
    @(negedge clk);
  endtask

  // Pulse stamps mostly march forward near the debounce boundary; some are
  // contact bounce, some jump far (possibly wrapping), and some are noise
  // that leaves the stimulus clock alone.
  function automatic logic [TIME_W-1:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      stamp_cursor = stamp_cursor + live_gap + $urandom_range(0, 3);
    end else if (pick <= 6) begin
      stamp_cursor = stamp_cursor + $urandom_range(0, live_gap);
    end else if (pick == 7) begin
      stamp_cursor = stamp_cursor + $urandom;
    end else if (pick == 8) begin
      return $urandom;
    end else begin
      stamp_cursor = stamp_cursor + $urandom_range(0, 1000);
    end
    return stamp_cursor;
  endfunction

  // Random seconds: a handful of pulses (now and then a flood of twenty to sixty
  // pulses), then a tick, sometimes a second tick with no pulses.
  task automatic run_seconds(input int unsigned target);
    int unsigned sent;
    int unsigned pulses;
    int unsigned k;
    sent = 0;
    while (sent < target) begin
      pulses = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      for (k = 0; k < pulses; k++) begin
        send_word(MODE_PULSE, next_stamp());
        sent++;
      end
      send_word(MODE_TICK, $urandom);
      sent++;
      if ($urandom_range(0, 9) == 0) begin
        send_word(MODE_TICK, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    stamp_cursor = $urandom;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults after reset, last accepted time zero. A stamp equal
    // to the gap is bounce; one more is a pulse.
    send_word(MODE_PULSE, 32'd0);
    send_word(MODE_PULSE, 32'd3);
    send_word(MODE_PULSE, 32'd4);
    send_word(MODE_PULSE, 32'd7);
    send_word(MODE_PULSE, 32'd8);
    send_word(MODE_PULSE, 32'hFFFF_FFFF);
    // Just past the wrap of the millisecond clock: still three and four ms on.
    send_word(MODE_PULSE, 32'h0000_0002);
    send_word(MODE_PULSE, 32'h0000_0003);
    // A tick ignores its stamp; a second tick closes an empty second.
    send_word(MODE_TICK, 32'hFFFF_FFFF);
    send_word(MODE_TICK, 32'h0000_0000);
    send_word(MODE_PULSE, 32'h8000_0000);
    send_word(MODE_PULSE, 32'h8000_0004);
    send_word(MODE_PULSE, 32'h8000_0008);

    // Ceiling lowered to one with three pulses already counted: the count
    // holds. With no debounce gap an equal stamp is still rejected.
    apply_settings(0, 1, 255);
    send_word(MODE_PULSE, 32'h8000_0008);
    send_word(MODE_PULSE, 32'h8000_0009);
    send_word(MODE_TICK, 32'h5555_5555);
    send_word(MODE_PULSE, 32'h8000_000A);
    send_word(MODE_PULSE, 32'h8000_000B);
    send_word(MODE_TICK, 32'hAAAA_AAAA);
    send_word(MODE_TICK, 32'h0F0F_0F0F);

    // Random phases over the extremes of every register, ceiling zero
    // among them, then random settings and the defaults once more.
    apply_settings(0, 511, 255);
    run_seconds(270);
    apply_settings(255, 1, 0);
    run_seconds(270);
    apply_settings(0, 0, 128);
    run_seconds(260);
    apply_settings($urandom_range(0, 255), $urandom_range(1, 500), $urandom_range(0, 255));
    run_seconds(270);
    apply_settings($urandom_range(0, 255), $urandom_range(1, 500), $urandom_range(0, 255));
    run_seconds(270);
    apply_settings(MIN_GAP_RST, COUNT_LIMIT_RST, SPEED_RST);
    run_seconds(270);

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/apwa_pkg.sv
design/apwa_ring.sv
design/apwa_cdiv.sv
design/anemometer_pulse_window_averager.sv
dv/tb_top.sv
